// ===== hw/rtl/lrupr_pkg.sv =====
`default_nettype none

package lrupr_pkg;

  localparam int MAX_FRAMES = 8;
  localparam int PAGE_BITS  = 16;

  localparam int PAGE_IN_W  = 16;
  localparam int CFG_W      = 4;
  localparam int COUNT_W    = 32;
  localparam int FRAME_W    = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W      = (FRAME_W > CFG_W) ? FRAME_W : CFG_W;

  localparam logic [CFG_W-1:0]   NUM_FRAMES_RESET = CFG_W'(4);
  localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [FRAME_W-1:0]   frame_cnt_t;
  typedef logic [COUNT_W-1:0]   count_t;

  // Shared by every cell of the stack for the item being taken
  typedef struct packed {
    logic step;   // an item is transferred this cycle
    logic fault;  // no resident entry matched
    logic clear;  // end of string: empty the stack after this item
  } cell_ctrl_t;

  // Keep the low PAGE_BITS of the reference, zero-fill when wider
  function automatic page_t to_page(input logic [PAGE_IN_W-1:0] pn);
    page_t p;
    p = '0;
    for (int b = 0; b < PAGE_BITS; b++) begin
      if (b < PAGE_IN_W) begin
        p[b] = pn[b];
      end
    end
    return p;
  endfunction

  // Clamp the configured frame count into 1..MAX_FRAMES
  function automatic frame_cnt_t clamp_frames(input logic [CFG_W-1:0] nf);
    logic [CMP_W-1:0] v;
    v = CMP_W'(nf);
    if (v == '0) begin
      v = CMP_W'(1);
    end else if (v > CMP_W'(MAX_FRAMES)) begin
      v = CMP_W'(MAX_FRAMES);
    end
    return v[FRAME_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lrupr_ifs.sv =====
`default_nettype none

interface lru_req_if;
  logic                              valid;
  logic                              ready;
  logic [lrupr_pkg::PAGE_IN_W-1:0]   page_id;
  logic                              end_of_string;
  modport source (output valid, output page_id, output end_of_string, input ready);
  modport sink   (input valid, input page_id, input end_of_string, output ready);
endinterface

interface lru_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            page_fault;
  logic [lrupr_pkg::COUNT_W-1:0]   fault_total;
  logic                            final_item;
  modport source (output valid, output page_fault, output fault_total, output final_item,
                  input ready);
  modport sink   (input valid, input page_fault, input fault_total, input final_item,
                  output ready);
endinterface

interface lru_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lrupr_pkg::CFG_W-1:0]   num_frames;
  modport source (output valid, output num_frames, input ready);
  modport sink   (input valid, input num_frames, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lrupr_cell.sv =====
`default_nettype none

// One stack position: compare against the reference, pass the match chain
// on, and take the neighbour above's entry when the stack shifts through.
module lrupr_cell (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire lrupr_pkg::cell_ctrl_t ctrl,
  input  wire logic                  active,
  input  wire lrupr_pkg::page_t      ref_page,
  input  wire lrupr_pkg::page_t      prev_page,
  input  wire logic                  prev_valid,
  input  wire logic                  seen_in,
  output lrupr_pkg::page_t           page,
  output logic                       valid,
  output logic                       seen_out
);

  logic match;

  assign match    = valid && active && (page == ref_page);
  assign seen_out = seen_in | match;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.step) begin
      if (ctrl.clear) begin
        valid <= 1'b0;
      end else if (ctrl.fault) begin
        // push down within the frames in use, drop anything beyond
        if (active) begin
          page  <= prev_page;
          valid <= prev_valid;
        end else begin
          valid <= 1'b0;
        end
      end else if (!seen_in) begin
        // at or above the hit position: shift down one
        page  <= prev_page;
        valid <= prev_valid;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lru_page_replacement_core.sv =====
`default_nettype none

// LRU page replacement stack, built as a chain of MAX_FRAMES compare/shift cells.
// Result: registered, and offered in the cycle after the reference is transferred.
// Throughput: one reference per cycle unless the output stalls; the match chain through
// the cells and the stack shift both settle within the cycle in which the reference is taken.
// Reset (synchronous, active high): stack empty, fault count zero, frames = 4.
module lru_page_replacement_core (
  input wire logic   clk,
  input wire logic   rst,
  lru_req_if.sink    req,
  lru_rsp_if.source  rsp,
  lru_cfg_if.sink    cfg
);

  localparam int N = lrupr_pkg::MAX_FRAMES;

  logic [lrupr_pkg::CFG_W-1:0] num_frames;
  lrupr_pkg::count_t           fault_counter;
  lrupr_pkg::count_t           fault_counter_next;
  lrupr_pkg::frame_cnt_t       frames;
  lrupr_pkg::page_t            ref_page;
  lrupr_pkg::cell_ctrl_t       ctrl;

  lrupr_pkg::page_t cell_page  [N];
  logic             cell_valid [N];
  logic             cell_active[N];
  logic             seen       [N+1];

  logic accept;
  logic fault;

  // User must write configuration only while nothing is in flight; unenforced. Always ready.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_frames <= lrupr_pkg::NUM_FRAMES_RESET;
    end else if (cfg.valid) begin
      num_frames <= cfg.num_frames;
    end
  end

  assign frames   = lrupr_pkg::clamp_frames(num_frames);
  assign ref_page = lrupr_pkg::to_page(req.page_id);

  // Take a new reference whenever the output register is empty or draining.
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // The match chain runs from the top of the stack downwards; the first hit
  // blocks shifting in every cell beneath it.
  assign seen[0] = 1'b0;
  assign fault   = !seen[N];

  assign ctrl.step  = accept;
  assign ctrl.fault = fault;
  assign ctrl.clear = req.end_of_string;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign cell_active[i] = (lrupr_pkg::frame_cnt_t'(i) < frames);

    if (i == 0) begin : g_top
      // The top cell is loaded with the reference itself
      lrupr_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .active     (cell_active[i]),
        .ref_page   (ref_page),
        .prev_page  (ref_page),
        .prev_valid (1'b1),
        .seen_in    (seen[i]),
        .page       (cell_page[i]),
        .valid      (cell_valid[i]),
        .seen_out   (seen[i+1])
      );
    end else begin : g_body
      lrupr_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .active     (cell_active[i]),
        .ref_page   (ref_page),
        .prev_page  (cell_page[i-1]),
        .prev_valid (cell_valid[i-1]),
        .seen_in    (seen[i]),
        .page       (cell_page[i]),
        .valid      (cell_valid[i]),
        .seen_out   (seen[i+1])
      );
    end
  end

  // Saturating fault count including this reference
  always_comb begin
    fault_counter_next = fault_counter;
    if (fault && (fault_counter != lrupr_pkg::COUNT_MAX)) begin
      fault_counter_next = fault_counter + lrupr_pkg::count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_counter <= '0;
    end else if (accept) begin
      // drop the count at the end of a string
      fault_counter <= req.end_of_string ? '0 : fault_counter_next;
    end
  end

  // Output register: hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.page_fault  <= fault;
      rsp.fault_total <= fault_counter_next;
      rsp.final_item  <= req.end_of_string;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lrupr_checker.sv =====
`default_nettype none

module lrupr_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic                      out_page_fault,
  input wire lrupr_pkg::count_t         out_fault_total
);

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // Every transferred reference yields a result in the next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("no result after an input transfer");

  // No input is taken while a result waits and is not being taken
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken over a stalled result");

  // A reported fault never comes with a zero fault total
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_page_fault |-> out_fault_total != '0)
    else $error("fault reported with zero total");

endmodule

bind lru_page_replacement_core lrupr_checker u_lrupr_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (req.valid),
  .in_ready        (req.ready),
  .out_valid       (rsp.valid),
  .out_ready       (rsp.ready),
  .out_page_fault  (rsp.page_fault),
  .out_fault_total (rsp.fault_total)
);

`default_nettype wire
